// ----- rtl/vncf_pkg.sv -----
// Shared widths, register map, reset values and controller-datapath command types.
package vncf_pkg;

   localparam int ROT_W       = 16;
   localparam int BODY_W      = 16;
   localparam int BARO_W      = 32;
   localparam int OUT_W       = 32;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 21;
   localparam int GRAV_W      = 21;
   localparam int DT_W        = 17;
   localparam int WEIGHT_W    = 17;
   localparam int SETTLE_W    = 16;

   localparam int MUL_A_W     = 34;
   localparam int MUL_B_W     = 22;
   localparam int PROD_W      = MUL_A_W + MUL_B_W;
   localparam int ACC_W       = 58;
   localparam int R8_W        = 41;
   localparam int R8_SPLIT    = 17;
   localparam int REL_W       = BARO_W + 1;
   localparam int ACCEL_FRAC  = 25;

   localparam logic [CSR_INDEX_W-1:0] REG_GRAVITY_SCALE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_STEP      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BARO_WEIGHT    = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_SETTLE_SAMPLES = 2'd3;

   localparam logic [GRAV_W-1:0]   GRAVITY_SCALE_RESET  = 21'd642689;
   localparam logic [DT_W-1:0]     TIME_STEP_RESET      = 17'd328;
   localparam logic [WEIGHT_W-1:0] BARO_WEIGHT_RESET    = 17'd1311;
   localparam logic [SETTLE_W-1:0] SETTLE_SAMPLES_RESET = 16'd2000;

   localparam logic [WEIGHT_W-1:0] W_ONE = 17'd65536;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_ROT_X,
      MUL_ROT_Y,
      MUL_ROT_Z,
      MUL_ACCG_G,
      MUL_NEGC_G,
      MUL_ACCEL_DT,
      MUL_VEL_ONE,
      MUL_R8LO_DT,
      MUL_R8HI_DT,
      MUL_POS_ONE,
      MUL_VEL_DT,
      MUL_P1_WINV,
      MUL_REL_W,
      MUL_V1_WINV,
      MUL_CLIMB_W
   } mul_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_ADD_SH,
      ACC_RND
   } acc_op_type;

   typedef enum logic [1:0] {
      RND_8,
      RND_9,
      RND_16,
      RND_25
   } rnd_sel_type;

   typedef enum logic [2:0] {
      CAP_NONE,
      CAP_ACCEL,
      CAP_R8,
      CAP_V1,
      CAP_P1,
      CAP_POS,
      CAP_VEL
   } cap_type;

   typedef struct packed {
      logic        load_in;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      rnd_sel_type rnd_sel;
      cap_type     cap;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic settling;
   } status_type;

endpackage

// ----- rtl/vncf_datapath.sv -----
// Datapath: configuration registers, filter state, shared multiplier, accumulator and rounding.
module vncf_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  vncf_pkg::cmd_type                      cmd,
   output vncf_pkg::status_type                   status,
   input  logic signed [vncf_pkg::ROT_W-1:0]      req_rot_zx,
   input  logic signed [vncf_pkg::ROT_W-1:0]      req_rot_zy,
   input  logic signed [vncf_pkg::ROT_W-1:0]      req_rot_zz,
   input  logic signed [vncf_pkg::BODY_W-1:0]     req_accel_body_x,
   input  logic signed [vncf_pkg::BODY_W-1:0]     req_accel_body_y,
   input  logic signed [vncf_pkg::BODY_W-1:0]     req_accel_body_z,
   input  logic signed [vncf_pkg::BARO_W-1:0]     req_baro_height,
   input  logic signed [vncf_pkg::BARO_W-1:0]     req_baro_climb_rate,
   input  logic                                   csr_write,
   input  logic [vncf_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [vncf_pkg::CSR_DATA_W-1:0]        csr_data,
   output logic signed [vncf_pkg::OUT_W-1:0]      rsp_earth_accel_z,
   output logic signed [vncf_pkg::OUT_W-1:0]      rsp_vertical_velocity,
   output logic signed [vncf_pkg::OUT_W-1:0]      rsp_vertical_position,
   output logic                                   rsp_settled
);
   import vncf_pkg::*;

   localparam logic signed [MUL_A_W-1:0] GRAV_OFFSET = -(MUL_A_W'(1) <<< ACCEL_FRAC);
   localparam logic signed [MUL_B_W-1:0] UNITY       = $signed(MUL_B_W'(W_ONE));

   logic [GRAV_W-1:0]            gravity_scale_ff;
   logic [DT_W-1:0]              time_step_ff;
   logic [WEIGHT_W-1:0]          baro_weight_ff;
   logic [SETTLE_W-1:0]          settle_samples_ff;
   logic [WEIGHT_W-1:0]          w_ff;
   logic [WEIGHT_W-1:0]          winv_ff;
   logic [WEIGHT_W-1:0]          w_in;

   logic [SETTLE_W-1:0]          settle_cnt_ff;
   logic signed [BARO_W-1:0]     ref_ff;
   logic signed [OUT_W-1:0]      vel_ff;
   logic signed [OUT_W-1:0]      pos_ff;

   logic signed [ROT_W-1:0]      rot_x_ff, rot_y_ff, rot_z_ff;
   logic signed [BODY_W-1:0]     body_x_ff, body_y_ff, body_z_ff;
   logic signed [BARO_W-1:0]     height_ff, climb_ff;
   logic signed [REL_W-1:0]      rel_ff;

   logic signed [MUL_A_W-1:0]    mul_a;
   logic signed [MUL_B_W-1:0]    mul_b;
   logic signed [PROD_W-1:0]     prod_ff;
   logic signed [ACC_W-1:0]      acc_ff;
   logic signed [ACC_W-1:0]      acc_in;
   logic [5:0]                   rnd_n;
   logic signed [ACC_W-1:0]      rnd_sum;
   logic signed [ACC_W-1:0]      rnd_val;
   logic signed [OUT_W-1:0]      rnd_sat;

   logic signed [OUT_W-1:0]      accel_ff;
   logic signed [R8_W-1:0]       r8_ff;
   logic signed [OUT_W-1:0]      v1_ff;
   logic signed [OUT_W-1:0]      p1_ff;
   logic                         settled_ff;

   function automatic logic signed [OUT_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
      logic [ACC_W-OUT_W:0] upper;
      upper = v[ACC_W-1:OUT_W-1];
      if ((&upper) || !(|upper)) begin
         return v[OUT_W-1:0];
      end else if (v[ACC_W-1]) begin
         return {1'b1, {(OUT_W-1){1'b0}}};
      end else begin
         return {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   assign status.settling = settle_cnt_ff < settle_samples_ff;
   assign w_in = (baro_weight_ff > W_ONE) ? W_ONE : baro_weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_scale_ff  <= GRAVITY_SCALE_RESET;
         time_step_ff      <= TIME_STEP_RESET;
         baro_weight_ff    <= BARO_WEIGHT_RESET;
         settle_samples_ff <= SETTLE_SAMPLES_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_GRAVITY_SCALE:  gravity_scale_ff  <= csr_data[GRAV_W-1:0];
            REG_TIME_STEP:      time_step_ff      <= csr_data[DT_W-1:0];
            REG_BARO_WEIGHT:    baro_weight_ff    <= csr_data[WEIGHT_W-1:0];
            REG_SETTLE_SAMPLES: settle_samples_ff <= csr_data[SETTLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      w_ff    <= w_in;
      winv_ff <= W_ONE - w_in;
      rel_ff  <= REL_W'(height_ff) - REL_W'(ref_ff);
      if (cmd.load_in) begin
         rot_x_ff  <= req_rot_zx;
         rot_y_ff  <= req_rot_zy;
         rot_z_ff  <= req_rot_zz;
         body_x_ff <= req_accel_body_x;
         body_y_ff <= req_accel_body_y;
         body_z_ff <= req_accel_body_z;
         height_ff <= req_baro_height;
         climb_ff  <= req_baro_climb_rate;
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_sel)
         MUL_ROT_X: begin
            mul_a = MUL_A_W'(rot_x_ff);
            mul_b = MUL_B_W'(body_x_ff);
         end
         MUL_ROT_Y: begin
            mul_a = MUL_A_W'(rot_y_ff);
            mul_b = MUL_B_W'(body_y_ff);
         end
         MUL_ROT_Z: begin
            mul_a = MUL_A_W'(rot_z_ff);
            mul_b = MUL_B_W'(body_z_ff);
         end
         MUL_ACCG_G: begin
            mul_a = acc_ff[MUL_A_W-1:0];
            mul_b = $signed(MUL_B_W'(gravity_scale_ff));
         end
         MUL_NEGC_G: begin
            mul_a = GRAV_OFFSET;
            mul_b = $signed(MUL_B_W'(gravity_scale_ff));
         end
         MUL_ACCEL_DT: begin
            mul_a = MUL_A_W'(accel_ff);
            mul_b = $signed(MUL_B_W'(time_step_ff));
         end
         MUL_VEL_ONE: begin
            mul_a = MUL_A_W'(vel_ff);
            mul_b = UNITY;
         end
         MUL_R8LO_DT: begin
            mul_a = $signed(MUL_A_W'(r8_ff[R8_SPLIT-1:0]));
            mul_b = $signed(MUL_B_W'(time_step_ff));
         end
         MUL_R8HI_DT: begin
            mul_a = MUL_A_W'($signed(r8_ff[R8_W-1:R8_SPLIT]));
            mul_b = $signed(MUL_B_W'(time_step_ff));
         end
         MUL_POS_ONE: begin
            mul_a = MUL_A_W'(pos_ff);
            mul_b = UNITY;
         end
         MUL_VEL_DT: begin
            mul_a = MUL_A_W'(vel_ff);
            mul_b = $signed(MUL_B_W'(time_step_ff));
         end
         MUL_P1_WINV: begin
            mul_a = MUL_A_W'(p1_ff);
            mul_b = $signed(MUL_B_W'(winv_ff));
         end
         MUL_REL_W: begin
            mul_a = MUL_A_W'(rel_ff);
            mul_b = $signed(MUL_B_W'(w_ff));
         end
         MUL_V1_WINV: begin
            mul_a = MUL_A_W'(v1_ff);
            mul_b = $signed(MUL_B_W'(winv_ff));
         end
         MUL_CLIMB_W: begin
            mul_a = MUL_A_W'(climb_ff);
            mul_b = $signed(MUL_B_W'(w_ff));
         end
         default: ;
      endcase
   end

   always_comb begin
      case (cmd.rnd_sel)
         RND_8:   rnd_n = 6'd8;
         RND_9:   rnd_n = 6'd9;
         RND_16:  rnd_n = 6'd16;
         RND_25:  rnd_n = 6'd25;
         default: rnd_n = 6'd16;
      endcase
      rnd_sum = acc_ff + (ACC_W'(1) <<< (rnd_n - 6'd1));
      rnd_val = rnd_sum >>> rnd_n;
      rnd_sat = sat32(rnd_val);
   end

   always_comb begin
      case (cmd.acc_op)
         ACC_LOAD:   acc_in = ACC_W'(prod_ff);
         ACC_ADD:    acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_ADD_SH: acc_in = acc_ff + (ACC_W'(prod_ff) <<< R8_SPLIT);
         ACC_RND:    acc_in = rnd_val;
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_sel != MUL_NONE) begin
         prod_ff <= mul_a * mul_b;
      end
      acc_ff <= acc_in;
      case (cmd.cap)
         CAP_ACCEL: begin
            accel_ff   <= rnd_sat;
            settled_ff <= !status.settling;
         end
         CAP_R8:  r8_ff <= rnd_val[R8_W-1:0];
         CAP_V1:  v1_ff <= rnd_sat;
         CAP_P1:  p1_ff <= rnd_sat;
         default: ;
      endcase
      if (cmd.finish) begin
         rsp_earth_accel_z     <= accel_ff;
         rsp_vertical_velocity <= vel_ff;
         rsp_vertical_position <= pos_ff;
         rsp_settled           <= settled_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_cnt_ff <= '0;
         ref_ff        <= '0;
         vel_ff        <= '0;
         pos_ff        <= '0;
      end else begin
         if (cmd.cap == CAP_POS) begin
            pos_ff <= rnd_sat;
         end
         if (cmd.cap == CAP_VEL) begin
            vel_ff <= rnd_sat;
         end
         if (cmd.finish && !settled_ff) begin
            settle_cnt_ff <= settle_cnt_ff + SETTLE_W'(1);
            ref_ff        <= height_ff;
         end
      end
   end

endmodule

// ----- rtl/vncf_ctrl.sv -----
// Controller: sequences the shared multiplier and accumulator over one sample and owns the handshakes.
module vncf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  vncf_pkg::status_type status,
   output vncf_pkg::cmd_type    cmd
);
   import vncf_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
      ST_I0, ST_I1, ST_I2, ST_I3, ST_I4, ST_I5, ST_I6, ST_I7,
      ST_I8, ST_I9, ST_I10, ST_I11, ST_I12, ST_I13, ST_I14, ST_I15,
      ST_FIN
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd         = '0;
      cmd.mul_sel = MUL_NONE;
      cmd.acc_op  = ACC_HOLD;
      cmd.rnd_sel = RND_16;
      cmd.cap     = CAP_NONE;
      case (state_ff)
         ST_IDLE: cmd.load_in = req_valid;
         ST_M0:   cmd.mul_sel = MUL_ROT_X;
         ST_M1: begin
            cmd.mul_sel = MUL_ROT_Y;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_M2: begin
            cmd.mul_sel = MUL_ROT_Z;
            cmd.acc_op  = ACC_ADD;
         end
         ST_M3:   cmd.acc_op  = ACC_ADD;
         ST_M4:   cmd.mul_sel = MUL_ACCG_G;
         ST_M5: begin
            cmd.mul_sel = MUL_NEGC_G;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_M6:   cmd.acc_op  = ACC_ADD;
         ST_M7: begin
            cmd.rnd_sel = RND_25;
            cmd.cap     = CAP_ACCEL;
         end
         ST_I0:   cmd.mul_sel = MUL_ACCEL_DT;
         ST_I1: begin
            cmd.mul_sel = MUL_VEL_ONE;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_I2: begin
            cmd.rnd_sel = RND_8;
            cmd.cap     = CAP_R8;
            cmd.acc_op  = ACC_ADD;
         end
         ST_I3: begin
            cmd.cap     = CAP_V1;
            cmd.mul_sel = MUL_R8LO_DT;
         end
         ST_I4: begin
            cmd.mul_sel = MUL_R8HI_DT;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_I5: begin
            cmd.mul_sel = MUL_POS_ONE;
            cmd.acc_op  = ACC_ADD_SH;
         end
         ST_I6: begin
            cmd.rnd_sel = RND_9;
            cmd.acc_op  = ACC_RND;
         end
         ST_I7: begin
            cmd.mul_sel = MUL_VEL_DT;
            cmd.acc_op  = ACC_ADD;
         end
         ST_I8:   cmd.acc_op  = ACC_ADD;
         ST_I9:   cmd.cap     = CAP_P1;
         ST_I10:  cmd.mul_sel = MUL_P1_WINV;
         ST_I11: begin
            cmd.mul_sel = MUL_REL_W;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_I12: begin
            cmd.mul_sel = MUL_V1_WINV;
            cmd.acc_op  = ACC_ADD;
         end
         ST_I13: begin
            cmd.cap     = CAP_POS;
            cmd.mul_sel = MUL_CLIMB_W;
            cmd.acc_op  = ACC_LOAD;
         end
         ST_I14:  cmd.acc_op  = ACC_ADD;
         ST_I15:  cmd.cap     = CAP_VEL;
         ST_FIN:  cmd.finish  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: if (req_valid) state_ff <= ST_M0;
            ST_M0:   state_ff <= ST_M1;
            ST_M1:   state_ff <= ST_M2;
            ST_M2:   state_ff <= ST_M3;
            ST_M3:   state_ff <= ST_M4;
            ST_M4:   state_ff <= ST_M5;
            ST_M5:   state_ff <= ST_M6;
            ST_M6:   state_ff <= ST_M7;
            ST_M7:   state_ff <= status.settling ? ST_FIN : ST_I0;
            ST_I0:   state_ff <= ST_I1;
            ST_I1:   state_ff <= ST_I2;
            ST_I2:   state_ff <= ST_I3;
            ST_I3:   state_ff <= ST_I4;
            ST_I4:   state_ff <= ST_I5;
            ST_I5:   state_ff <= ST_I6;
            ST_I6:   state_ff <= ST_I7;
            ST_I7:   state_ff <= ST_I8;
            ST_I8:   state_ff <= ST_I9;
            ST_I9:   state_ff <= ST_I10;
            ST_I10:  state_ff <= ST_I11;
            ST_I11:  state_ff <= ST_I12;
            ST_I12:  state_ff <= ST_I13;
            ST_I13:  state_ff <= ST_I14;
            ST_I14:  state_ff <= ST_I15;
            ST_I15:  state_ff <= ST_FIN;
            ST_FIN:  if (out_free) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ----- rtl/vertical_nav_complementary_filter.sv -----
// Top level of the vertical navigation complementary filter.
// One input transaction is taken at a time; its result is ready after the measurement steps
// (and the integration steps once settled), and the next input transaction is taken only
// once the controller is back in idle, because every product runs through a single shared
// 34 x 22 bit multiplier feeding one accumulator, one product per cycle. The result sits
// in an output register, so the next input transaction is taken while the previous result
// still waits; a sample that finishes before that result is taken waits in its last step.
// Configuration writes are always accepted; to take effect for the next sample they must
// come between samples (not enforced by the block); no clearing pass is needed after reset.
module vertical_nav_complementary_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zx,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zy,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zz,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_x,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_y,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_z,
   input  logic signed [vncf_pkg::BARO_W-1:0]  req_baro_height,
   input  logic signed [vncf_pkg::BARO_W-1:0]  req_baro_climb_rate,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [vncf_pkg::OUT_W-1:0]   rsp_earth_accel_z,
   output logic signed [vncf_pkg::OUT_W-1:0]   rsp_vertical_velocity,
   output logic signed [vncf_pkg::OUT_W-1:0]   rsp_vertical_position,
   output logic                                rsp_settled,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vncf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vncf_pkg::CSR_DATA_W-1:0]     csr_data
);
   import vncf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   vncf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   vncf_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_rot_zx            (req_rot_zx),
      .req_rot_zy            (req_rot_zy),
      .req_rot_zz            (req_rot_zz),
      .req_accel_body_x      (req_accel_body_x),
      .req_accel_body_y      (req_accel_body_y),
      .req_accel_body_z      (req_accel_body_z),
      .req_baro_height       (req_baro_height),
      .req_baro_climb_rate   (req_baro_climb_rate),
      .csr_write             (csr_valid && csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .rsp_earth_accel_z     (rsp_earth_accel_z),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_vertical_position (rsp_vertical_position),
      .rsp_settled           (rsp_settled)
   );

endmodule

// ----- test/vncf_checker.sv -----
`timescale 1ns / 100ps
// Checker that predicts every filter result from the accepted samples and compares it.
module vncf_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zx,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zy,
   input  logic signed [vncf_pkg::ROT_W-1:0]   req_rot_zz,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_x,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_y,
   input  logic signed [vncf_pkg::BODY_W-1:0]  req_accel_body_z,
   input  logic signed [vncf_pkg::BARO_W-1:0]  req_baro_height,
   input  logic signed [vncf_pkg::BARO_W-1:0]  req_baro_climb_rate,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [vncf_pkg::OUT_W-1:0]   rsp_earth_accel_z,
   input  logic signed [vncf_pkg::OUT_W-1:0]   rsp_vertical_velocity,
   input  logic signed [vncf_pkg::OUT_W-1:0]   rsp_vertical_position,
   input  logic                                rsp_settled,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  logic [vncf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [vncf_pkg::CSR_DATA_W-1:0]     csr_data,
   input  logic                                closing,
   output int                                  fail_count,
   output int                                  pending_count
);
   import vncf_pkg::*;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;

   typedef struct {
      logic signed [OUT_W-1:0] earth_accel_z;
      logic signed [OUT_W-1:0] vertical_velocity;
      logic signed [OUT_W-1:0] vertical_position;
      logic                    settled;
   } estimate_type;

   logic [GRAV_W-1:0]          gravity_scale;
   logic [DT_W-1:0]            time_step;
   logic [WEIGHT_W-1:0]        baro_weight;
   logic [SETTLE_W-1:0]        settle_samples;
   logic [SETTLE_W-1:0]        settle_count;
   logic signed [BARO_W-1:0]   reference_height;
   logic signed [BARO_W-1:0]   velocity;
   logic signed [BARO_W-1:0]   position;
   estimate_type               estimate_q[$];
   estimate_type               wanted;
   int                         mismatch_count = 0;
   logic                       closed = 1'b0;

   task automatic report_error(input string msg);
      $display("[%0t] vncf_checker: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic longint round_shift(input longint value, input int n);
      return (value + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint sat32(input longint value);
      if (value > S32_MAX) begin
         return S32_MAX;
      end
      if (value < S32_MIN) begin
         return S32_MIN;
      end
      return value;
   endfunction

   function automatic longint blend(input longint inertial, input longint baro,
                                    input longint weight_value);
      return sat32(round_shift(inertial * (longint'(W_ONE) - weight_value)
                               + baro * weight_value, 16));
   endfunction

   function automatic estimate_type filter_sample(
      input logic signed [ROT_W-1:0]  zx, zy, zz,
      input logic signed [BODY_W-1:0] ax, ay, az,
      input logic signed [BARO_W-1:0] height, climb);
      estimate_type result;
      longint g_sum, g, accel, dt, weight_value, accel_dt, half_term, pos_pred, p1, v1, rel;
      g_sum = longint'(zx) * longint'(ax) + longint'(zy) * longint'(ay)
            + longint'(zz) * longint'(az);
      g = longint'(gravity_scale);
      accel = sat32(round_shift(g_sum * g - (g << ACCEL_FRAC), ACCEL_FRAC));
      result.settled = 1'b0;
      if (settle_count < settle_samples) begin
         settle_count = settle_count + SETTLE_W'(1);
         reference_height = height;
      end else begin
         dt = longint'(time_step);
         weight_value = (baro_weight > W_ONE) ? longint'(W_ONE) : longint'(baro_weight);
         accel_dt = accel * dt;
         half_term = round_shift(round_shift(accel_dt, 8) * dt, 9);
         pos_pred = longint'(position) * 65536 + longint'(velocity) * dt + half_term;
         p1 = sat32(round_shift(pos_pred, 16));
         v1 = sat32(longint'(velocity) + round_shift(accel_dt, 16));
         rel = longint'(height) - longint'(reference_height);
         position = BARO_W'(blend(p1, rel, weight_value));
         velocity = BARO_W'(blend(v1, longint'(climb), weight_value));
         result.settled = 1'b1;
      end
      result.earth_accel_z = OUT_W'(accel);
      result.vertical_velocity = velocity;
      result.vertical_position = position;
      return result;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         gravity_scale = GRAVITY_SCALE_RESET;
         time_step = TIME_STEP_RESET;
         baro_weight = BARO_WEIGHT_RESET;
         settle_samples = SETTLE_SAMPLES_RESET;
         settle_count = '0;
         reference_height = '0;
         velocity = '0;
         position = '0;
         estimate_q.delete();
         closed = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_GRAVITY_SCALE:  gravity_scale = csr_data[GRAV_W-1:0];
               REG_TIME_STEP:      time_step = csr_data[DT_W-1:0];
               REG_BARO_WEIGHT:    baro_weight = csr_data[WEIGHT_W-1:0];
               REG_SETTLE_SAMPLES: settle_samples = csr_data[SETTLE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            estimate_q.push_back(filter_sample(req_rot_zx, req_rot_zy, req_rot_zz,
                                               req_accel_body_x, req_accel_body_y,
                                               req_accel_body_z, req_baro_height,
                                               req_baro_climb_rate));
         end
         if (rsp_valid && rsp_ready) begin
            if (estimate_q.size() == 0) begin
               report_error("result transaction with no expectation waiting");
            end else begin
               wanted = estimate_q.pop_front();
               if (rsp_earth_accel_z !== wanted.earth_accel_z) begin
                  report_error($sformatf("earth_accel_z got %0d, expected %0d",
                                         rsp_earth_accel_z, wanted.earth_accel_z));
               end
               if (rsp_vertical_velocity !== wanted.vertical_velocity) begin
                  report_error($sformatf("vertical_velocity got %0d, expected %0d",
                                         rsp_vertical_velocity, wanted.vertical_velocity));
               end
               if (rsp_vertical_position !== wanted.vertical_position) begin
                  report_error($sformatf("vertical_position got %0d, expected %0d",
                                         rsp_vertical_position, wanted.vertical_position));
               end
               if (rsp_settled !== wanted.settled) begin
                  report_error($sformatf("settled got %0b, expected %0b",
                                         rsp_settled, wanted.settled));
               end
            end
         end
         if (closing && !closed) begin
            closed = 1'b1;
            if (estimate_q.size() != 0) begin
               report_error($sformatf("%0d expected results never arrived",
                                      estimate_q.size()));
            end
         end
      end
      pending_count <= estimate_q.size();
      fail_count <= mismatch_count;
   end

endmodule

// ----- test/vertical_nav_complementary_filter_tb.sv -----
`timescale 1ns / 100ps
// Testbench top that drives samples and register writes into the filter and gives the verdict.
module vertical_nav_complementary_filter_tb;
   import vncf_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASES       = 10;
   localparam int PHASE_ITEMS  = 40;
   localparam int ROT_ONE      = 16384;
   localparam int ACC_ONE_G    = 2048;
   localparam int Q16_ONE      = 65536;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   typedef struct packed {
      logic signed [ROT_W-1:0]  rot_zx;
      logic signed [ROT_W-1:0]  rot_zy;
      logic signed [ROT_W-1:0]  rot_zz;
      logic signed [BODY_W-1:0] accel_x;
      logic signed [BODY_W-1:0] accel_y;
      logic signed [BODY_W-1:0] accel_z;
      logic signed [BARO_W-1:0] height;
      logic signed [BARO_W-1:0] climb;
   } sample_type;

   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic signed [ROT_W-1:0]   req_rot_zx = '0;
   logic signed [ROT_W-1:0]   req_rot_zy = '0;
   logic signed [ROT_W-1:0]   req_rot_zz = '0;
   logic signed [BODY_W-1:0]  req_accel_body_x = '0;
   logic signed [BODY_W-1:0]  req_accel_body_y = '0;
   logic signed [BODY_W-1:0]  req_accel_body_z = '0;
   logic signed [BARO_W-1:0]  req_baro_height = '0;
   logic signed [BARO_W-1:0]  req_baro_climb_rate = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]   rsp_earth_accel_z;
   logic signed [OUT_W-1:0]   rsp_vertical_velocity;
   logic signed [OUT_W-1:0]   rsp_vertical_position;
   logic                      rsp_settled;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_W-1:0]    csr_index = REG_GRAVITY_SCALE;
   logic [CSR_DATA_W-1:0]     csr_data = '0;
   logic                      closing = 1'b0;
   idle_mode_type             idle_mode = IDLE_NONE;
   int                        fail_count;
   int                        pending_count;
   int                        cycle_count;

   vertical_nav_complementary_filter u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_rot_zx            (req_rot_zx),
      .req_rot_zy            (req_rot_zy),
      .req_rot_zz            (req_rot_zz),
      .req_accel_body_x      (req_accel_body_x),
      .req_accel_body_y      (req_accel_body_y),
      .req_accel_body_z      (req_accel_body_z),
      .req_baro_height       (req_baro_height),
      .req_baro_climb_rate   (req_baro_climb_rate),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_earth_accel_z     (rsp_earth_accel_z),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_vertical_position (rsp_vertical_position),
      .rsp_settled           (rsp_settled),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   vncf_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_rot_zx          (req_rot_zx),
      .req_rot_zy          (req_rot_zy),
      .req_rot_zz          (req_rot_zz),
      .req_accel_body_x    (req_accel_body_x),
      .req_accel_body_y    (req_accel_body_y),
      .req_accel_body_z    (req_accel_body_z),
      .req_baro_height     (req_baro_height),
      .req_baro_climb_rate (req_baro_climb_rate),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_earth_accel_z   (rsp_earth_accel_z),
      .rsp_vertical_velocity (rsp_vertical_velocity),
      .rsp_vertical_position (rsp_vertical_position),
      .rsp_settled         (rsp_settled),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .closing             (closing),
      .fail_count          (fail_count),
      .pending_count       (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         case (idle_mode)
            IDLE_RECEIVER: rsp_ready <= ($urandom_range(99) >= 84);
            IDLE_BOTH:     rsp_ready <= ($urandom_range(99) >= 37);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // Unused upper bits of the narrower writes carry random junk, which the block must drop.
   task automatic write_registers(input int unsigned gravity, step, weight_value, settle);
      logic [CSR_INDEX_W-1:0] index_list [4];
      int unsigned            value_list [4];
      int                     width_list [4];
      index_list = '{REG_GRAVITY_SCALE, REG_TIME_STEP, REG_BARO_WEIGHT, REG_SETTLE_SAMPLES};
      value_list = '{gravity, step, weight_value, settle};
      width_list = '{GRAV_W, DT_W, WEIGHT_W, SETTLE_W};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[i];
         csr_data <= CSR_DATA_W'(value_list[i] | ($urandom << width_list[i]));
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
   endtask

   task automatic send_sample(input int zx, zy, zz, ax, ay, az, height, climb);
      int idle_pct;
      case (idle_mode)
         IDLE_SENDER: idle_pct = 84;
         IDLE_BOTH:   idle_pct = 37;
         default:     idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rot_zx <= ROT_W'(zx);
      req_rot_zy <= ROT_W'(zy);
      req_rot_zz <= ROT_W'(zz);
      req_accel_body_x <= BODY_W'(ax);
      req_accel_body_y <= BODY_W'(ay);
      req_accel_body_z <= BODY_W'(az);
      req_baro_height <= height;
      req_baro_climb_rate <= climb;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   function automatic int pick_extreme(input int low, input int high);
      case ($urandom_range(3))
         0:       return low;
         1:       return high;
         2:       return 0;
         default: return -1;
      endcase
   endfunction

   function automatic sample_type random_sample();
      sample_type draw;
      int         kind;
      kind = $urandom_range(99);
      if (kind < 60) begin
         // Near-level flight with noisy accelerometer and barometer.
         draw.rot_zx = ROT_W'(int'($urandom_range(6000)) - 3000);
         draw.rot_zy = ROT_W'(int'($urandom_range(6000)) - 3000);
         draw.rot_zz = ROT_W'(ROT_ONE - int'($urandom_range(1500)));
         draw.accel_x = BODY_W'(int'($urandom_range(800)) - 400);
         draw.accel_y = BODY_W'(int'($urandom_range(800)) - 400);
         draw.accel_z = BODY_W'(ACC_ONE_G + int'($urandom_range(1200)) - 600);
         draw.height = 100 * Q16_ONE + int'($urandom_range(200000)) - 100000;
         draw.climb = int'($urandom_range(4 * Q16_ONE)) - 2 * Q16_ONE;
      end else if (kind < 85) begin
         draw.rot_zx = ROT_W'(int'($urandom_range(2 * ROT_ONE)) - ROT_ONE);
         draw.rot_zy = ROT_W'(int'($urandom_range(2 * ROT_ONE)) - ROT_ONE);
         draw.rot_zz = ROT_W'(int'($urandom_range(2 * ROT_ONE)) - ROT_ONE);
         draw.accel_x = BODY_W'($urandom);
         draw.accel_y = BODY_W'($urandom);
         draw.accel_z = BODY_W'($urandom);
         draw.height = $urandom;
         draw.climb = $urandom;
      end else begin
         draw.rot_zx = ROT_W'(pick_extreme(-ROT_ONE, ROT_ONE));
         draw.rot_zy = ROT_W'(pick_extreme(-ROT_ONE, ROT_ONE));
         draw.rot_zz = ROT_W'(pick_extreme(-ROT_ONE, ROT_ONE));
         draw.accel_x = BODY_W'(pick_extreme(-32768, 32767));
         draw.accel_y = BODY_W'(pick_extreme(-32768, 32767));
         draw.accel_z = BODY_W'(pick_extreme(-32768, 32767));
         draw.height = pick_extreme(int'(32'h80000000), int'(32'h7FFFFFFF));
         draw.climb = pick_extreme(int'(32'h80000000), int'(32'h7FFFFFFF));
      end
      return draw;
   endfunction

   initial begin
      sample_type  draw;
      int unsigned gravity, step, weight_value, settle;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Two settling samples latch the reference, then normal integration.
      write_registers(32'(GRAVITY_SCALE_RESET), 32'(TIME_STEP_RESET),
                      32'(BARO_WEIGHT_RESET), 2);
      send_sample(0, 0, 0, 0, 0, 0, 0, 0);
      send_sample(0, 0, ROT_ONE, 0, 0, ACC_ONE_G, 32'h80000000, 0);
      send_sample(0, 0, ROT_ONE, 0, 0, ACC_ONE_G, 1000 * Q16_ONE, Q16_ONE);
      send_sample(ROT_ONE, ROT_ONE, ROT_ONE, 32767, 32767, 32767,
                  32'h7FFFFFFF, 32'h7FFFFFFF);
      send_sample(-ROT_ONE, -ROT_ONE, -ROT_ONE, -32768, -32768, -32768,
                  32'h80000000, 32'h80000000);
      send_sample(ROT_ONE, -ROT_ONE, ROT_ONE, -32768, 32767, -32768, 0, -1);
      send_sample(-ROT_ONE, ROT_ONE, -ROT_ONE, 32767, -32768, 32767, -1, 0);
      send_sample(0, 0, ROT_ONE, 0, 0, 0, 0, 0);
      send_sample(11585, 0, 11585, 1448, 0, 1448, Q16_ONE, -Q16_ONE);
      wait_drained();

      // Zero time step with a weight above one: the estimates follow the barometer.
      write_registers(0, 0, 131071, 2);
      send_sample(0, 0, ROT_ONE, 0, 0, ACC_ONE_G, 32'h7FFFFFFF, 32'h7FFFFFFF);
      wait_drained();

      // Full inertial weight and a one-second step drive both estimates into saturation.
      write_registers(2097151, Q16_ONE, 0, 2);
      send_sample(ROT_ONE, ROT_ONE, ROT_ONE, 32767, 32767, 32767, 0, 0);
      send_sample(ROT_ONE, ROT_ONE, ROT_ONE, -32768, -32768, -32768, 0, 0);
      wait_drained();

      write_registers(1048576, 0, Q16_ONE, 2);
      send_sample(0, 0, ROT_ONE, 0, 0, ACC_ONE_G, 32'h80000000, 32'h80000000);
      wait_drained();

      write_registers(2097151, Q16_ONE, 0, 2);
      send_sample(ROT_ONE, ROT_ONE, ROT_ONE, -32768, -32768, -32768, 0, 0);
      wait_drained();

      // Raising the settle count above the counter resumes settling.
      write_registers(1048576, 131071, Q16_ONE, 65535);
      send_sample(0, 0, ROT_ONE, 0, 0, ACC_ONE_G, 5 * Q16_ONE, 0);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_drained();
         idle_mode <= idle_mode_type'(phase % 4);
         if (phase % 3 == 0) begin
            gravity = $urandom_range(2097151);
         end else begin
            gravity = GRAVITY_SCALE_RESET - 20000 + $urandom_range(40000);
         end
         case ($urandom_range(5))
            0:       step = $urandom_range(131071);
            1:       step = $urandom_range(Q16_ONE, 1);
            default: step = $urandom_range(2000, 100);
         endcase
         case ($urandom_range(4))
            0:       weight_value = $urandom_range(131071);
            1:       weight_value = $urandom_range(Q16_ONE);
            2:       weight_value = Q16_ONE;
            default: weight_value = $urandom_range(4000);
         endcase
         case ($urandom_range(9))
            0:       settle = 65535;
            1:       settle = 0;
            2, 3:    settle = $urandom_range(60, 9);
            default: settle = $urandom_range(8);
         endcase
         write_registers(gravity, step, weight_value, settle);
         repeat (PHASE_ITEMS) begin
            draw = random_sample();
            send_sample(int'(draw.rot_zx), int'(draw.rot_zy), int'(draw.rot_zz),
                        int'(draw.accel_x), int'(draw.accel_y), int'(draw.accel_z),
                        int'(draw.height), int'(draw.climb));
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      closing <= 1'b1;
      repeat (2) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
